/* hw/rtl/mqd_pkg.sv */
// Shared types and constants for the MQTT packet deframer.
package mqd_pkg;

   // Default cap on the number of remaining-length bytes
   localparam int MAX_LENGTH_BYTES_DEF = 4;

   // Packet type of PUBLISH, taken from the header byte 0x30
   localparam logic [3:0] TYPE_PUBLISH = 4'(8'h30 >> 4);

   // Byte kind codes
   localparam logic [2:0] KIND_HEADER = 3'd0;
   localparam logic [2:0] KIND_LENGTH = 3'd1;
   localparam logic [2:0] KIND_TLEN   = 3'd2;
   localparam logic [2:0] KIND_TOPIC  = 3'd3;
   localparam logic [2:0] KIND_PID    = 3'd4;
   localparam logic [2:0] KIND_PAY    = 3'd5;
   localparam logic [2:0] KIND_OTHER  = 3'd6;

   // Error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_LEN_LONG = 2'd1;
   localparam logic [1:0] ERR_TOPIC    = 2'd2;

   // One result item
   typedef struct packed {
      logic [2:0]  byte_kind;
      logic [3:0]  packet_type;
      logic [3:0]  packet_flags;
      logic [27:0] remaining_length;
      logic [7:0]  byte_value;
      logic        end_of_packet;
      logic [1:0]  error_code;
   } mqd_result_type;

endpackage

/* hw/rtl/mqd_parse.sv */
// Parser state and per-byte classification for the MQTT packet deframer.
module mqd_parse
   import mqd_pkg::*;
#(
   parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     in_byte,
   output mqd_result_type result
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LENGTH,
      PH_BODY
   } phase_type;

   localparam logic [2:0] MaxCount = 3'(MAX_LENGTH_BYTES);

   phase_type      phase_ff, phase_in;
   logic [3:0]     type_ff, type_in;
   logic [3:0]     flags_ff, flags_in;
   logic [27:0]    accum_ff, accum_in;
   logic [2:0]     lcount_ff, lcount_in;
   logic [27:0]    body_ff, body_in;
   logic [15:0]    topic_ff, topic_in;
   mqd_result_type result_ff, result_in;

   logic [27:0]    len_add;
   logic [28:0]    body_next;
   logic           last;
   logic           has_pid;
   logic [15:0]    topic_full;
   logic [16:0]    need;
   logic [16:0]    topic_end;
   logic [16:0]    pid_end;

   // Place the 7-bit length group at its weight
   always_comb begin
      case (lcount_ff[1:0])
         2'd0:    len_add = {21'b0, in_byte[6:0]};
         2'd1:    len_add = {14'b0, in_byte[6:0], 7'b0};
         2'd2:    len_add = {7'b0, in_byte[6:0], 14'b0};
         default: len_add = {in_byte[6:0], 21'b0};
      endcase
   end

   // Body position bookkeeping
   assign body_next  = {1'b0, body_ff} + 29'd1;
   assign last       = body_next >= {1'b0, accum_ff};
   assign has_pid    = |flags_ff[2:1];
   assign topic_full = {topic_ff[15:8], in_byte};
   assign need       = 17'd2 + {1'b0, topic_full} + (has_pid ? 17'd2 : 17'd0);
   assign topic_end  = 17'd2 + {1'b0, topic_ff};
   assign pid_end    = 17'd4 + {1'b0, topic_ff};

   // Classify the byte and compute the next parser state
   always_comb begin
      phase_in  = phase_ff;
      type_in   = type_ff;
      flags_in  = flags_ff;
      accum_in  = accum_ff;
      lcount_in = lcount_ff;
      body_in   = body_ff;
      topic_in  = topic_ff;

      result_in.byte_kind     = KIND_OTHER;
      result_in.byte_value    = in_byte;
      result_in.end_of_packet = 1'b0;
      result_in.error_code    = ERR_NONE;

      unique case (phase_ff)
         PH_HEADER: begin
            result_in.byte_kind = KIND_HEADER;
            type_in   = in_byte[7:4];
            flags_in  = in_byte[3:0];
            accum_in  = '0;
            lcount_in = '0;
            body_in   = '0;
            topic_in  = '0;
            phase_in  = PH_LENGTH;
         end
         PH_LENGTH: begin
            result_in.byte_kind = KIND_LENGTH;
            accum_in  = accum_ff + len_add;
            lcount_in = lcount_ff + 3'd1;
            if (!in_byte[7]) begin
               if (accum_in == 28'd0) begin
                  result_in.end_of_packet = 1'b1;
                  phase_in = PH_HEADER;
               end else begin
                  body_in  = '0;
                  phase_in = PH_BODY;
               end
            end else if (lcount_in >= MaxCount) begin
               // length field too long: drop the packet
               result_in.error_code = ERR_LEN_LONG;
               phase_in = PH_HEADER;
            end
         end
         PH_BODY: begin
            if (type_ff == TYPE_PUBLISH) begin
               if (body_ff == 28'd0) begin
                  result_in.byte_kind = KIND_TLEN;
                  topic_in = {in_byte, 8'h00};
                  if (last) begin
                     result_in.error_code = ERR_TOPIC;
                  end
               end else if (body_ff == 28'd1) begin
                  result_in.byte_kind = KIND_TLEN;
                  topic_in = topic_full;
                  if ({11'b0, need} > accum_ff) begin
                     result_in.error_code = ERR_TOPIC;
                  end
               end else if (body_ff < {11'b0, topic_end}) begin
                  result_in.byte_kind = KIND_TOPIC;
               end else if (has_pid && (body_ff < {11'b0, pid_end})) begin
                  result_in.byte_kind = KIND_PID;
               end else begin
                  result_in.byte_kind = KIND_PAY;
               end
            end
            body_in = body_next[27:0];
            if (last) begin
               result_in.end_of_packet = 1'b1;
               phase_in = PH_HEADER;
            end
         end
         default: begin
            phase_in = PH_HEADER;
         end
      endcase

      result_in.packet_type      = type_in;
      result_in.packet_flags     = flags_in;
      result_in.remaining_length = accum_in;
   end

   // Hold state and the result register; advance only on a step
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         type_ff   <= '0;
         flags_ff  <= '0;
         accum_ff  <= '0;
         lcount_ff <= '0;
         body_ff   <= '0;
         topic_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         type_ff   <= type_in;
         flags_ff  <= flags_in;
         accum_ff  <= accum_in;
         lcount_ff <= lcount_in;
         body_ff   <= body_in;
         topic_ff  <= topic_in;
      end
      if (step) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* hw/rtl/mqtt_packet_deframer.sv */
// An accepted item passes through the input register and then the result register.
// Throughput: one byte per cycle, unless rsp_ready holds back the result register.
// While a finished result waits on rsp_ready, an empty input register takes one more item.
// Reset (synchronous, active high) empties both registers and returns the parser
// to expecting a header byte; no clearing pass is needed.
// Top level of the MQTT packet deframer.
module mqtt_packet_deframer
   import mqd_pkg::*;
#(
   parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_byte_kind,
   output logic [3:0]  rsp_packet_type,
   output logic [3:0]  rsp_packet_flags,
   output logic [27:0] rsp_remaining_length,
   output logic [7:0]  rsp_byte_value,
   output logic        rsp_end_of_packet,
   output logic [1:0]  rsp_error_code
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           advance;
   mqd_result_type result;

   // Move the pipeline when the result register is free or being drained
   assign advance     = !rsp_valid_ff || rsp_ready;
   assign req_ready   = advance || !in_valid_ff;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   mqd_parse #(
      .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance && in_valid_ff),
      .in_byte (in_byte_ff),
      .result  (result)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_byte_kind        = result.byte_kind;
   assign rsp_packet_type      = result.packet_type;
   assign rsp_packet_flags     = result.packet_flags;
   assign rsp_remaining_length = result.remaining_length;
   assign rsp_byte_value       = result.byte_value;
   assign rsp_end_of_packet    = result.end_of_packet;
   assign rsp_error_code       = result.error_code;

endmodule

/* hw/rtl/mqd_checker.sv */
// Port-level assertions for the MQTT packet deframer, bound to the top level.
module mqd_checker
   import mqd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_byte_kind,
   input logic [27:0] rsp_remaining_length,
   input logic [7:0]  rsp_byte_value,
   input logic        rsp_end_of_packet,
   input logic [1:0]  rsp_error_code
);

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_value)
         && $stable(rsp_byte_kind) && $stable(rsp_remaining_length))
      else $error("stalled result item changed");

   // No result item right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A header byte starts clean
   a_header_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_kind == KIND_HEADER |->
         rsp_remaining_length == 28'd0 && !rsp_end_of_packet && rsp_error_code == ERR_NONE)
      else $error("header byte with length, end or error");

   // A long length field is flagged on a length byte and never ends the packet
   a_len_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_LEN_LONG |->
         rsp_byte_kind == KIND_LENGTH && !rsp_end_of_packet)
      else $error("length error on wrong byte");

   // A topic overrun is flagged only on a topic-length byte
   a_topic_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_TOPIC |-> rsp_byte_kind == KIND_TLEN)
      else $error("topic error on wrong byte");

endmodule

bind mqtt_packet_deframer mqd_checker u_mqd_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_byte_kind        (rsp_byte_kind),
   .rsp_remaining_length (rsp_remaining_length),
   .rsp_byte_value       (rsp_byte_value),
   .rsp_end_of_packet    (rsp_end_of_packet),
   .rsp_error_code       (rsp_error_code)
);

/* dv/mqtt_packet_deframer_tb.sv */
// Self-checking testbench for the MQTT packet deframer: directed and random byte streams.
module mqtt_packet_deframer_tb;
   import mqd_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned PRINT_LIMIT  = 50;
   localparam int unsigned PHASE_ITEMS  = 125;

   typedef logic [7:0] byte_queue_type[$];
   typedef enum logic [1:0] {PH_HEADER, PH_LENGTH, PH_BODY} parse_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_byte_kind;
   logic [3:0]  rsp_packet_type;
   logic [3:0]  rsp_packet_flags;
   logic [27:0] rsp_remaining_length;
   logic [7:0]  rsp_byte_value;
   logic        rsp_end_of_packet;
   logic [1:0]  rsp_error_code;

   // Parser state mirrored by the predictor
   parse_phase_type prs_phase = PH_HEADER;
   logic [3:0]   prs_type = '0;
   logic [3:0]   prs_flags = '0;
   logic [27:0]  prs_len = '0;
   logic [2:0]   prs_len_bytes = '0;
   logic [27:0]  prs_body = '0;
   logic [15:0]  prs_topic = '0;

   mqd_result_type tag_queue[$];
   int unsigned    mismatch_count = 0;
   int unsigned    tags_checked = 0;
   int unsigned    items_sent = 0;
   int unsigned    cycle_count = 0;
   int unsigned    send_gap_pct = 0;
   int unsigned    recv_stall_pct = 0;

   mqtt_packet_deframer u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_in_byte          (req_in_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_byte_kind        (rsp_byte_kind),
      .rsp_packet_type      (rsp_packet_type),
      .rsp_packet_flags     (rsp_packet_flags),
      .rsp_remaining_length (rsp_remaining_length),
      .rsp_byte_value       (rsp_byte_value),
      .rsp_end_of_packet    (rsp_end_of_packet),
      .rsp_error_code       (rsp_error_code)
   );

   // Generate the clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the receiver at random
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Tag one accepted byte and advance the mirrored parser state
   function automatic mqd_result_type tag_byte(input logic [7:0] b);
      mqd_result_type r;
      int unsigned    idx;
      logic           last;
      logic           has_pid;
      r.byte_kind     = KIND_OTHER;
      r.byte_value    = b;
      r.end_of_packet = 1'b0;
      r.error_code    = ERR_NONE;
      case (prs_phase)
         PH_HEADER: begin
            r.byte_kind   = KIND_HEADER;
            prs_type      = b[7:4];
            prs_flags     = b[3:0];
            prs_len       = '0;
            prs_len_bytes = '0;
            prs_body      = '0;
            prs_topic     = '0;
            prs_phase     = PH_LENGTH;
         end
         PH_LENGTH: begin
            r.byte_kind   = KIND_LENGTH;
            prs_len       = prs_len + (28'(b[6:0]) << (7 * prs_len_bytes[1:0]));
            prs_len_bytes = prs_len_bytes + 3'd1;
            if (!b[7]) begin
               if (prs_len == '0) begin
                  r.end_of_packet = 1'b1;
                  prs_phase       = PH_HEADER;
               end else begin
                  prs_body  = '0;
                  prs_phase = PH_BODY;
               end
            end else if (prs_len_bytes >= MAX_LENGTH_BYTES_DEF) begin
               r.error_code = ERR_LEN_LONG;
               prs_phase    = PH_HEADER;
            end
         end
         default: begin
            idx     = prs_body;
            last    = (idx + 1) >= prs_len;
            has_pid = (prs_flags & 4'h6) != 4'h0;
            if (prs_type == TYPE_PUBLISH) begin
               if (idx == 0) begin
                  r.byte_kind = KIND_TLEN;
                  prs_topic   = {b, 8'h00};
                  if (last) r.error_code = ERR_TOPIC;
               end else if (idx == 1) begin
                  r.byte_kind = KIND_TLEN;
                  prs_topic   = prs_topic | 16'(b);
                  if (2 + prs_topic + (has_pid ? 2 : 0) > prs_len) r.error_code = ERR_TOPIC;
               end else if (idx < 2 + prs_topic) begin
                  r.byte_kind = KIND_TOPIC;
               end else if (has_pid && idx < 4 + prs_topic) begin
                  r.byte_kind = KIND_PID;
               end else begin
                  r.byte_kind = KIND_PAY;
               end
            end
            prs_body = 28'(idx + 1);
            if (last) begin
               r.end_of_packet = 1'b1;
               prs_phase       = PH_HEADER;
            end
         end
      endcase
      r.packet_type      = prs_type;
      r.packet_flags     = prs_flags;
      r.remaining_length = prs_len;
      // Clear the per-packet counters once the packet is done
      if (prs_phase == PH_HEADER && r.byte_kind != KIND_HEADER) begin
         prs_len       = '0;
         prs_len_bytes = '0;
         prs_body      = '0;
         prs_topic     = '0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got)
         report_mismatch($sformatf("result %0d %s: want 0x%0h got 0x%0h",
                                   tags_checked, name, want, got));
   endtask

   // Predict on each accepted byte, then check each accepted result
   always @(posedge clock) begin : tag_monitor
      mqd_result_type got;
      mqd_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) tag_queue.push_back(tag_byte(req_in_byte));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_byte_kind, rsp_packet_type, rsp_packet_flags, rsp_remaining_length,
                   rsp_byte_value, rsp_end_of_packet, rsp_error_code};
            if (tag_queue.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with none pending", tags_checked));
            end else begin
               want = tag_queue.pop_front();
               check_field("byte_kind", want.byte_kind, got.byte_kind);
               check_field("packet_type", want.packet_type, got.packet_type);
               check_field("packet_flags", want.packet_flags, got.packet_flags);
               check_field("remaining_length", want.remaining_length, got.remaining_length);
               check_field("byte_value", want.byte_value, got.byte_value);
               check_field("end_of_packet", want.end_of_packet, got.end_of_packet);
               check_field("error_code", want.error_code, got.error_code);
            end
            tags_checked++;
         end
      end
   end

   // Send one item; called and returns at a falling edge, valid stays up for the next item
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_bytes(input byte_queue_type bytes);
      foreach (bytes[i]) send_byte(bytes[i]);
   endtask

   // Zero-length bodies, with a short and a full four-byte length field
   task automatic test_empty_body();
      byte_queue_type pkt;
      pkt = {8'h00, 8'h00, 8'hE0, 8'h80, 8'h80, 8'h80, 8'h00};
      send_bytes(pkt);
   endtask

   // Length field whose fourth byte still asks for more
   task automatic test_long_length_field();
      byte_queue_type pkt;
      pkt = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_bytes(pkt);
   endtask

   // PUBLISH with QoS 1: topic length, topic, packet id, payload
   task automatic test_publish_fields();
      byte_queue_type pkt;
      pkt = {8'h32, 8'h07, 8'h00, 8'h02, 8'h61, 8'h62, 8'h00, 8'h01, 8'h55};
      send_bytes(pkt);
   endtask

   // PUBLISH whose topic overruns the body, and one with a single body byte
   task automatic test_topic_overrun();
      byte_queue_type pkt;
      pkt = {8'h30, 8'h01, 8'hAB, 8'h3F, 8'h03, 8'h00, 8'h05, 8'h11};
      send_bytes(pkt);
   endtask

   // Build one random packet: mostly well formed, some broken
   task automatic send_random_packet();
      byte_queue_type pkt;
      int unsigned pick;
      int unsigned body_size;
      int unsigned n;
      int unsigned tlen;
      logic [3:0]  ptype;
      pick = $urandom_range(99);
      if (pick < 8) begin
         // Drop the packet with an over-long length field
         pkt = {8'($urandom), 8'h80 | 8'($urandom), 8'h80 | 8'($urandom),
                8'h80 | 8'($urandom), 8'h80 | 8'($urandom)};
      end else begin
         ptype     = (pick < 60) ? TYPE_PUBLISH : 4'($urandom);
         body_size = ($urandom_range(19) == 0) ? $urandom_range(300, 128)
                                               : $urandom_range(24);
         pkt.push_back({ptype, 4'($urandom)});
         n = body_size;
         do begin
            pkt.push_back(8'(n & 'h7f) | ((n > 127) ? 8'h80 : 8'h00));
            n = n >> 7;
         end while (n != 0);
         for (int i = 0; i < body_size; i++) pkt.push_back(8'($urandom));
         // Give most publish topics a length that fits the body
         if (ptype == TYPE_PUBLISH && body_size >= 2 && $urandom_range(9) != 0) begin
            tlen = $urandom_range(body_size - 2);
            pkt[pkt.size() - body_size]     = 8'(tlen >> 8);
            pkt[pkt.size() - body_size + 1] = 8'(tlen);
         end
      end
      send_bytes(pkt);
   endtask

   task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct);
      int unsigned start;
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
      start          = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_random_packet();
   endtask

   // Largest length field; the packet is left open at the end of the run
   task automatic test_max_length_field();
      byte_queue_type pkt;
      pkt = {8'h35, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h04, 8'h74, 8'h65, 8'h73, 8'h74,
             8'h12, 8'h34, 8'hC3, 8'h3C};
      send_bytes(pkt);
   endtask

   initial begin
      send_gap_pct   = 33;
      recv_stall_pct = 50;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_body();
      test_long_length_field();
      test_publish_fields();
      test_topic_overrun();
      test_random_traffic(33, 50);
      test_random_traffic(50, 33);
      test_random_traffic(0, 0);
      test_max_length_field();

      // Drain outstanding results
      req_valid <= 1'b0;
      while (tag_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
